// ----- hdl/gs5c_pkg.sv -----
`timescale 1ns / 1ps
// gs5c_pkg: shared types, register codes and the root table builder for the
// 5x5 smoothing core. No dependencies.
package gs5c_pkg;

	localparam int PIX_W  = 24;
	localparam int CONF_W = 8;
	localparam int ENT_W  = PIX_W + CONF_W;
	localparam int LW_W   = 13;
	localparam int WGT_W  = 19;
	localparam int ROOT_W = 17;
	localparam int ROW_W  = 16;
	localparam int OCOL_W = 12;
	localparam int SM_W   = 24;
	localparam int SMC_W  = 25;
	localparam int CFG_IDX_W = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 80;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_W_CENTRE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_W_NEAR_EDG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_W_FAR_EDG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_W_NEAR_CNR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_W_KNIGHT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_W_FAR_CNR  = 3'd6;

	typedef enum logic [2:0] {
		WC_CENTRE   = 3'd0,
		WC_NEAR_EDG = 3'd1,
		WC_FAR_EDG  = 3'd2,
		WC_NEAR_CNR = 3'd3,
		WC_KNIGHT   = 3'd4,
		WC_FAR_CNR  = 3'd5
	} wclass_t;

	typedef logic [ROOT_W-1:0] root_tab_t [256];

	// distance class of tap (y,x) from the window centre
	function automatic wclass_t wclass(input logic [2:0] y, input logic [2:0] x);
		logic [1:0] a, b, lo, hi;
		wclass_t wc;
		a  = (y >= 3'd2) ? 2'(y - 3'd2) : 2'(3'd2 - y);
		b  = (x >= 3'd2) ? 2'(x - 3'd2) : 2'(3'd2 - x);
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (hi == 2'd0)      wc = WC_CENTRE;
		else if (lo == 2'd0) wc = (hi == 2'd1) ? WC_NEAR_EDG : WC_FAR_EDG;
		else if (lo == 2'd1) wc = (hi == 2'd1) ? WC_NEAR_CNR : WC_KNIGHT;
		else                 wc = WC_FAR_CNR;
		return wc;
	endfunction

	// round(65536*sqrt(c/100)), evaluated at elaboration
	function automatic root_tab_t build_root_tab();
		root_tab_t t;
		logic [63:0] x, r, b;
		for (int c = 0; c < 256; c++) begin
			x = (64'(c) << 32) / 64'd25;
			r = '0;
			b = 64'h4000_0000_0000_0000;
			for (int i = 0; i < 32; i++) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			t[c] = ROOT_W'((r + 64'd1) >> 1);
		end
		return t;
	endfunction

endpackage

// ----- hdl/gaussian_smooth_5x5_conf_core.sv -----
`timescale 1ns / 1ps
// gaussian_smooth_5x5_conf_core: 5x5 Gaussian smoothing with confidence-root
// weighted second sum. Depends on gs5c_pkg.
//
// channel  dir  handshake              payload
// s_       in   s_tvalid / s_tready    tdata: pixel_value, confidence; tuser: frame_start
// m_       out  m_tvalid / m_tready    tdata: smoothed, smoothed_conf, centre_column,
//                                      centre_row; tlast: row_last
// cfg_     in   cfg_we                 cfg_addr, cfg_wdata
//
// Border pixel: accept, then line store read-modify-write.
// Interior pixel: accept, line store update, then one shared multiplier pair walks the 25 taps, one per cycle.
// Line stores: one 4-bank-wide memory with a registered read, written back the cycle after.
// The output register lets the next pixel enter while a result waits on m_tready.
// arst_n clears control state, counters, window and registers but not line store, rd_q or products.
module gaussian_smooth_5x5_conf_core #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [23:0] pixel_value, [31:24] confidence
	input  logic [gs5c_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [0] frame_start
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [23:0] smoothed, [48:24] smoothed_conf, [60:49] centre_column,
	// [76:61] centre_row, [79:77] zero
	output logic [gs5c_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [gs5c_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [gs5c_pkg::WGT_W-1:0]         cfg_wdata
);
	import gs5c_pkg::*;

	localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > LW_W) ? WW : LW_W;
	localparam int MEM_W = 4 * ENT_W;
	localparam int P_W   = WGT_W + 1 + PIX_W;
	localparam int PC_W  = P_W + ROOT_W + 1;
	localparam int AS_W  = 49;
	localparam int ASC_W = 64;
	localparam root_tab_t ROOT_TAB = build_root_tab();

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_UPD   = 5'b00010,
		S_MAC   = 5'b00100,
		S_DRAIN = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q;
	logic [LW_W-1:0]  lw_q;
	logic [WGT_W-1:0] wgt_q [6];
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [ENT_W-1:0] win_q [5][5];
	logic [MEM_W-1:0] mem [MAX_WIDTH];
	logic [MEM_W-1:0] rd_q;
	logic [ENT_W-1:0] ent_q;
	logic [CW-1:0]    c_q;
	logic [ROW_W-1:0] r_q;
	logic             last_q;
	logic [2:0]       ty_q, tx_q;
	logic signed [P_W-1:0]   p_s1;
	logic [ROOT_W-1:0]       root_s1;
	logic                    v_s1;
	logic signed [PC_W-1:0]  pc_s2;
	logic                    v_s2;
	logic signed [AS_W-1:0]  acc_s_q;
	logic signed [ASC_W-1:0] acc_sc_q;
	logic                    out_v_q;
	logic [SM_W-1:0]         sm_q;
	logic [SMC_W-1:0]        smc_q;
	logic [OCOL_W-1:0]       ocol_q;
	logic [ROW_W-1:0]        orow_q;
	logic                    olast_q;

	logic [CMPW-1:0] lw_ext, w_eff;
	logic [CMPW-1:0] c_raw, c_ext;
	logic [CW-1:0]   c_cur;
	logic [ROW_W-1:0] r_cur;
	logic            acc_in;
	logic [ENT_W-1:0] tap;
	logic signed [AS_W-AS_W+31-1:0] s_rnd;
	logic signed [31:0] sc_rnd;
	logic [SM_W-1:0]  s_sat;
	logic [SMC_W-1:0] sc_sat;
	logic            prod;

	assign s_tready = (state_q == S_IDLE);
	assign acc_in   = s_tvalid && s_tready;

	always_comb begin
		lw_ext = CMPW'(lw_q);
		if (lw_ext > CMPW'(MAX_WIDTH)) w_eff = CMPW'(MAX_WIDTH);
		else if (lw_ext < CMPW'(5))    w_eff = CMPW'(5);
		else                           w_eff = lw_ext;
		c_raw = s_tuser ? '0 : CMPW'(col_q);
		c_ext = (c_raw >= w_eff) ? w_eff - CMPW'(1) : c_raw;
		c_cur = CW'(c_ext);
		r_cur = s_tuser ? '0 : row_q;
	end

	assign tap  = win_q[ty_q][tx_q];
	assign prod = (r_q >= ROW_W'(4)) && (c_q >= CW'(4));

	always_comb begin
		s_rnd  = 31'((acc_s_q + AS_W'(64'sd131072)) >>> 18);
		sc_rnd = 32'((acc_sc_q + ASC_W'(64'sd8589934592)) >>> 34);
		if (s_rnd > 31'sd8388607)        s_sat = SM_W'(24'h7FFFFF);
		else if (s_rnd < -31'sd8388608)  s_sat = SM_W'(24'h800000);
		else                             s_sat = SM_W'(s_rnd);
		if (sc_rnd > 32'sd16777215)      sc_sat = SMC_W'(25'h0FFFFFF);
		else if (sc_rnd < -32'sd16777216) sc_sat = SMC_W'(25'h1000000);
		else                             sc_sat = SMC_W'(sc_rnd);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= LW_W'(4096);
			wgt_q[0] <= WGT_W'(262144);
			for (int i = 1; i < 6; i++) wgt_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_LINE_WIDTH) lw_q <= cfg_wdata[LW_W-1:0];
			else if (cfg_addr >= CFG_W_CENTRE && cfg_addr <= CFG_W_FAR_CNR)
				wgt_q[3'(cfg_addr - CFG_W_CENTRE)] <= cfg_wdata;
		end
	end

	// line store: all four banks of one column side by side
	always_ff @(posedge clk) begin
		if (acc_in) rd_q <= mem[c_cur];
		if (state_q == S_UPD)
			mem[c_q] <= {ent_q, rd_q[3*ENT_W +: ENT_W], rd_q[2*ENT_W +: ENT_W],
				rd_q[ENT_W +: ENT_W]};
	end

	// multiply pipeline
	always_ff @(posedge clk) begin
		p_s1    <= P_W'($signed({1'b0, wgt_q[wclass(ty_q, tx_q)]})) *
			P_W'($signed(tap[PIX_W-1:0]));
		root_s1 <= ROOT_TAB[tap[ENT_W-1:PIX_W]];
		pc_s2   <= PC_W'(p_s1) * PC_W'($signed({1'b0, root_s1}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			col_q    <= '0;
			row_q    <= '0;
			for (int y = 0; y < 5; y++)
				for (int x = 0; x < 5; x++) win_q[y][x] <= '0;
			ent_q    <= '0;
			c_q      <= '0;
			r_q      <= '0;
			last_q   <= 1'b0;
			ty_q     <= '0;
			tx_q     <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			acc_s_q  <= '0;
			acc_sc_q <= '0;
			out_v_q  <= 1'b0;
			sm_q     <= '0;
			smc_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			olast_q  <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_MAC);
			v_s2 <= v_s1;
			if (v_s2) acc_sc_q <= acc_sc_q + ASC_W'(pc_s2);
			if (v_s1) acc_s_q  <= acc_s_q + AS_W'(p_s1);
			if (out_v_q && m_tready && state_q != S_FIN) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						ent_q  <= s_tdata[ENT_W-1:0];
						c_q    <= c_cur;
						r_q    <= r_cur;
						last_q <= (c_ext + CMPW'(1) == w_eff);
						if (c_ext + CMPW'(1) >= w_eff) begin
							col_q <= '0;
							row_q <= (r_cur != '1) ? r_cur + ROW_W'(1) : r_cur;
						end else begin
							col_q <= c_cur + CW'(1);
							row_q <= r_cur;
						end
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					for (int y = 0; y < 5; y++)
						for (int x = 0; x < 4; x++) win_q[y][x] <= win_q[y][x+1];
					for (int k = 0; k < 4; k++) win_q[k][4] <= rd_q[k*ENT_W +: ENT_W];
					win_q[4][4] <= ent_q;
					ty_q     <= '0;
					tx_q     <= '0;
					acc_s_q  <= '0;
					acc_sc_q <= '0;
					state_q  <= prod ? S_MAC : S_IDLE;
				end
				S_MAC: begin
					if (tx_q == 3'd4) begin
						tx_q <= '0;
						ty_q <= ty_q + 3'd1;
						if (ty_q == 3'd4) state_q <= S_DRAIN;
					end else begin
						tx_q <= tx_q + 3'd1;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						sm_q    <= s_sat;
						smc_q   <= sc_sat;
						ocol_q  <= OCOL_W'(c_q - CW'(2));
						orow_q  <= r_q - ROW_W'(2);
						olast_q <= last_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {3'b000, orow_q, ocol_q, smc_q, sm_q};

	a_accept_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_UPD)
		else $error("accepted pixel did not enter line store update");
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_FIN))
		else $error("result appeared outside finalize");
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> !(ty_q > 3'd4 || tx_q > 3'd4))
		else $error("tap counter out of window");

endmodule
